/* rtl/sdis_pkg.sv */
// shared types and constants of the signed decimal integer scanner
`default_nettype none
package sdis_pkg;

   localparam int CHAR_W    = 8;
   localparam int MAG_W     = 31;
   localparam int COUNT_W   = 9;
   localparam int POS_OUT_W = 9;

   localparam int DEFAULT_LINE_LENGTH = 256;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [MAG_W-1:0]   MAG_MAX   = {MAG_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              end_of_line;
   } sdis_item_type;

   typedef struct packed {
      logic                 found;
      logic [MAG_W-1:0]     magnitude;
      logic                 negative;
      logic [COUNT_W-1:0]   digit_count;
      logic [POS_OUT_W-1:0] end_position;
      logic                 overflow;
   } sdis_result_type;

endpackage
`default_nettype wire

/* rtl/sdis_input_stage.sv */
// input register stage of the scanner
`default_nettype none
module sdis_input_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire sdis_pkg::sdis_item_type in_item,
   input  wire logic                   advance,
   output logic                        out_valid,
   output sdis_pkg::sdis_item_type     out_item
);
   import sdis_pkg::*;

   logic          valid_ff;
   sdis_item_type item_ff;

   // free when empty or when the held word moves on this cycle
   assign in_ready  = !valid_ff || advance;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule
`default_nettype wire

/* rtl/sdis_scan_core.sv */
// scan state and single-step number recognition
`default_nettype none
module sdis_scan_core #(
   parameter int LINE_LENGTH = sdis_pkg::DEFAULT_LINE_LENGTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step_en,
   input  wire sdis_pkg::sdis_item_type  item,
   output logic                          result_valid,
   output sdis_pkg::sdis_result_type     result
);
   import sdis_pkg::*;

   localparam int POS_W = $clog2(LINE_LENGTH + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_LENGTH);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_SIGN,
      MODE_DIGITS
   } mode_type;

   mode_type           mode_ff,   mode_in;
   logic               neg_ff,    neg_in;
   logic [MAG_W-1:0]   mag_ff,    mag_in;
   logic               sat_ff,    sat_in;
   logic [COUNT_W-1:0] digits_ff, digits_in;
   logic [POS_W-1:0]   pos_ff,    pos_in;

   logic                 in_line;
   logic                 is_digit;
   logic                 is_sign;
   logic                 is_dot;
   logic [3:0]           digit_val;
   logic [MAG_W+3:0]     scaled;
   logic [POS_W-1:0]     pos_inc;
   logic [POS_W+POS_OUT_W-1:0] pos_now_ext;
   logic [POS_W+POS_OUT_W-1:0] pos_inc_ext;

   assign in_line   = pos_ff < POS_LIMIT;
   assign is_digit  = item.character inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_sign   = (item.character == CHAR_MINUS) || (item.character == CHAR_PLUS);
   assign is_dot    = item.character == CHAR_DOT;
   assign digit_val = item.character[3:0];

   // running value times ten plus the new digit
   assign scaled = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1)
                 + {{MAG_W{1'b0}}, digit_val};

   assign pos_inc     = in_line ? pos_ff + 1'b1 : pos_ff;
   assign pos_now_ext = {{POS_OUT_W{1'b0}}, pos_ff};
   assign pos_inc_ext = {{POS_OUT_W{1'b0}}, pos_inc};

   always_comb begin
      logic look_fresh;
      look_fresh   = 1'b0;
      mode_in      = mode_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      sat_in       = sat_ff;
      digits_in    = digits_ff;
      pos_in       = pos_inc;
      result_valid = 1'b0;
      result       = '0;

      case (mode_ff)
         MODE_DIGITS: begin
            if (in_line && is_digit) begin
               if (|scaled[MAG_W+3:MAG_W]) begin
                  mag_in = MAG_MAX;
                  sat_in = 1'b1;
               end else begin
                  mag_in = scaled[MAG_W-1:0];
               end
               if (digits_ff != COUNT_MAX) begin
                  digits_in = digits_ff + 1'b1;
               end
            end else begin
               result_valid        = 1'b1;
               result.found        = 1'b1;
               result.magnitude    = mag_ff;
               result.negative     = neg_ff;
               result.digit_count  = digits_ff;
               result.end_position = pos_now_ext[POS_OUT_W-1:0];
               result.overflow     = sat_ff;
               mode_in   = MODE_IDLE;
               neg_in    = 1'b0;
               mag_in    = '0;
               sat_in    = 1'b0;
               digits_in = '0;
            end
         end
         MODE_SIGN: begin
            if (in_line && is_digit) begin
               mode_in   = MODE_DIGITS;
               mag_in    = {{(MAG_W-4){1'b0}}, digit_val};
               sat_in    = 1'b0;
               digits_in = COUNT_W'(1);
            end else if (in_line && is_dot) begin
               // sign then dot reads as a found zero
               result_valid        = 1'b1;
               result.found        = 1'b1;
               result.negative     = neg_ff;
               result.end_position = pos_now_ext[POS_OUT_W-1:0];
               mode_in   = MODE_IDLE;
               neg_in    = 1'b0;
               mag_in    = '0;
               sat_in    = 1'b0;
               digits_in = '0;
            end else begin
               look_fresh = 1'b1;
            end
         end
         default: begin
            look_fresh = 1'b1;
         end
      endcase

      // dropped sign or idle: judge the character on its own
      if (look_fresh) begin
         mag_in    = '0;
         sat_in    = 1'b0;
         digits_in = '0;
         if (in_line && is_sign) begin
            mode_in = MODE_SIGN;
            neg_in  = item.character == CHAR_MINUS;
         end else if (in_line && is_digit) begin
            mode_in   = MODE_DIGITS;
            neg_in    = 1'b0;
            mag_in    = {{(MAG_W-4){1'b0}}, digit_val};
            digits_in = COUNT_W'(1);
         end else begin
            mode_in = MODE_IDLE;
            neg_in  = 1'b0;
         end
      end

      if (item.end_of_line) begin
         if (!result_valid) begin
            result_valid = 1'b1;
            if (mode_in == MODE_DIGITS) begin
               result.found        = 1'b1;
               result.magnitude    = mag_in;
               result.negative     = neg_in;
               result.digit_count  = digits_in;
               result.end_position = pos_inc_ext[POS_OUT_W-1:0];
               result.overflow     = sat_in;
            end
         end
         mode_in   = MODE_IDLE;
         neg_in    = 1'b0;
         mag_in    = '0;
         sat_in    = 1'b0;
         digits_in = '0;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         neg_ff    <= 1'b0;
         mag_ff    <= '0;
         sat_ff    <= 1'b0;
         digits_ff <= '0;
         pos_ff    <= '0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         neg_ff    <= neg_in;
         mag_ff    <= mag_in;
         sat_ff    <= sat_in;
         digits_ff <= digits_in;
         pos_ff    <= pos_in;
      end
   end

`ifndef SYNTHESIS
   a_digits_match_mode: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DIGITS) == (digits_ff != '0))
      else $error("digit count disagrees with scan mode");

   a_sat_holds_max: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (mag_ff == MAG_MAX))
      else $error("saturated without maximum magnitude");

   a_not_found_clean: assert property (@(posedge clock) disable iff (reset)
      (result_valid && !result.found) |->
         (result.magnitude == '0 && !result.negative && result.digit_count == '0
          && result.end_position == '0 && !result.overflow))
      else $error("not-found word carries data");

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.end_of_line) |=> (mode_ff == MODE_IDLE && pos_ff == '0))
      else $error("state not cleared after end of line");
`endif

endmodule
`default_nettype wire

/* rtl/signed_decimal_integer_scanner.sv */
// top level of the signed decimal integer scanner
// The scanner takes one ASCII character per word, with an end-of-line mark on
// the last one, and reports each signed decimal integer it finds: magnitude
// (saturated at 2147483647 with overflow set), sign, digit count and the index
// of the character that ended it, or one past the last digit at a line end. A
// word yields zero or one result word. It accepts a new word every cycle unless
// a word is held and the result register is full and not drained; a word passes
// an input register, then one step of scan logic whose longest path is the
// multiply-by-ten-and-add of the running magnitude, then the result register,
// which loads when the held word steps. A new word is taken while a result still
// waits only if the input register is empty.
`default_nettype none
module signed_decimal_integer_scanner #(
   parameter int LINE_LENGTH = sdis_pkg::DEFAULT_LINE_LENGTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // character words
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [sdis_pkg::CHAR_W-1:0]       req_character,
   input  wire logic                              req_end_of_line,
   // result words
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_found,
   output logic [sdis_pkg::MAG_W-1:0]             rsp_magnitude,
   output logic                                   rsp_negative,
   output logic [sdis_pkg::COUNT_W-1:0]           rsp_digit_count,
   output logic [sdis_pkg::POS_OUT_W-1:0]         rsp_end_position,
   output logic                                   rsp_overflow
);
   import sdis_pkg::*;

   sdis_item_type   req_item;
   sdis_item_type   held_item;
   logic            held_valid;
   logic            advance;
   logic            step_en;
   logic            result_valid;
   sdis_result_type result;

   logic            rsp_valid_ff;
   sdis_result_type rsp_ff;

   assign req_item.character   = req_character;
   assign req_item.end_of_line = req_end_of_line;

   // the held word may move when the result register is empty or being drained
   assign advance = !rsp_valid_ff || rsp_ready;
   assign step_en = held_valid && advance;

   sdis_input_stage u_input_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .advance   (advance),
      .out_valid (held_valid),
      .out_item  (held_item)
   );

   sdis_scan_core #(
      .LINE_LENGTH (LINE_LENGTH)
   ) u_scan_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .item         (held_item),
      .result_valid (result_valid),
      .result       (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en && result_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && result_valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_ff.found;
   assign rsp_magnitude    = rsp_ff.magnitude;
   assign rsp_negative     = rsp_ff.negative;
   assign rsp_digit_count  = rsp_ff.digit_count;
   assign rsp_end_position = rsp_ff.end_position;
   assign rsp_overflow     = rsp_ff.overflow;

endmodule
`default_nettype wire

/* tb/sv/tb_signed_decimal_integer_scanner.sv */
// testbench of the signed decimal integer scanner, directed and random lines against a predictor
`default_nettype none
module tb_signed_decimal_integer_scanner;
   import sdis_pkg::*;

   localparam int LINE_LEN       = DEFAULT_LINE_LENGTH;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
   localparam int HOLD_CYCLES    = 40;    // long receiver stall, fills the block
   localparam int DRAIN_CYCLES   = 8;     // margin for a stray result after the queue drains
   localparam int PHASE_WORDS    = 50;

   // scan modes of the predictor
   typedef enum logic [1:0] {
      SEEK_NUMBER,
      SIGN_HELD,
      IN_DIGITS
   } scan_mode_type;

   // one directed word; pinned rows carry a hand-written result that is queued in place of the
   // predicted one
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              eol;
      logic              pinned;
      sdis_result_type   want;
   } scan_row_type;

   localparam sdis_result_type NOT_FOUND = '0;

   localparam scan_row_type DIRECTED_ROWS [24] = '{
      // lines of one word with no number, extremes of the character
      '{8'h00, 1'b1, 1'b1, NOT_FOUND},
      '{8'hFF, 1'b1, 1'b1, NOT_FOUND},
      // negative number closed by end of line, position just past the digit
      '{CHAR_MINUS, 1'b0, 1'b0, '0},
      '{"7", 1'b1, 1'b1, '{1'b1, 31'd7, 1'b1, 9'd1, 9'd2, 1'b0}},
      // sign then dot is a found zero, then a line end with nothing pending
      '{CHAR_PLUS, 1'b0, 1'b0, '0},
      '{CHAR_DOT, 1'b0, 1'b1, '{1'b1, 31'd0, 1'b0, 9'd0, 9'd1, 1'b0}},
      '{"x", 1'b1, 1'b1, NOT_FOUND},
      // doubled sign drops the first, a sign after digits terminates
      '{CHAR_MINUS, 1'b0, 1'b0, '0},
      '{CHAR_MINUS, 1'b0, 1'b0, '0},
      '{"5", 1'b0, 1'b0, '0},
      '{CHAR_PLUS, 1'b1, 1'b1, '{1'b1, 31'd5, 1'b1, 9'd1, 9'd3, 1'b0}},
      // ten nines saturate the magnitude
      '{CHAR_NINE, 1'b0, 1'b0, '0},
      '{CHAR_NINE, 1'b0, 1'b0, '0},
      '{CHAR_NINE, 1'b0, 1'b0, '0},
      '{CHAR_NINE, 1'b0, 1'b0, '0},
      '{CHAR_NINE, 1'b0, 1'b0, '0},
      '{CHAR_NINE, 1'b0, 1'b0, '0},
      '{CHAR_NINE, 1'b0, 1'b0, '0},
      '{CHAR_NINE, 1'b0, 1'b0, '0},
      '{CHAR_NINE, 1'b0, 1'b0, '0},
      '{CHAR_NINE, 1'b0, 1'b0, '0},
      '{" ", 1'b1, 1'b1, '{1'b1, MAG_MAX, 1'b0, 9'd10, 9'd10, 1'b1}},
      // zero ended by a minus on the last word, left to the predictor
      '{CHAR_ZERO, 1'b0, 1'b0, '0},
      '{CHAR_MINUS, 1'b1, 1'b0, '0}
   };

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic [CHAR_W-1:0]    req_character   = '0;
   logic                 req_end_of_line = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   logic                 rsp_found;
   logic [MAG_W-1:0]     rsp_magnitude;
   logic                 rsp_negative;
   logic [COUNT_W-1:0]   rsp_digit_count;
   logic [POS_OUT_W-1:0] rsp_end_position;
   logic                 rsp_overflow;

   // predictor state, mirrors the scan registers
   scan_mode_type        pred_mode      = SEEK_NUMBER;
   logic                 pred_negative  = 1'b0;
   logic [MAG_W-1:0]     pred_magnitude = '0;
   logic                 pred_saturated = 1'b0;
   logic [COUNT_W-1:0]   pred_digits    = '0;
   int                   pred_position  = 0;

   sdis_result_type      numbers_due[$];  // results still owed by the block, oldest first
   int                   mismatches     = 0;

   // idling odds in percent, set by the phase sequence
   int                   send_idle_pct  = 0;
   int                   recv_idle_pct  = 0;

   // long receiver stall: main bumps the request, the receiver counts it out
   int                   hold_serial    = 0;
   int                   hold_taken     = 0;
   int                   hold_left      = 0;

   int                   quiet_cycles   = 0;

   signed_decimal_integer_scanner #(
      .LINE_LENGTH(LINE_LEN)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_character   (req_character),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_magnitude   (rsp_magnitude),
      .rsp_negative    (rsp_negative),
      .rsp_digit_count (rsp_digit_count),
      .rsp_end_position(rsp_end_position),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one character through the scan; returns 1 when the word yields a result
   function automatic bit step_scanner(input logic [CHAR_W-1:0] ch, input logic eol,
                                       output sdis_result_type res);
      bit          in_line;
      bit          is_digit;
      bit          is_sign;
      bit          emitted;
      logic [63:0] wide;
      int          pos;
      pos      = pred_position;
      in_line  = pos < LINE_LEN;
      is_digit = ch >= CHAR_ZERO && ch <= CHAR_NINE;
      is_sign  = ch == CHAR_MINUS || ch == CHAR_PLUS;
      emitted  = 1'b0;
      res      = '0;
      if (pred_mode == IN_DIGITS && in_line && is_digit) begin
         // multiply by ten and add, clamp at the 31-bit maximum
         wide = 64'(pred_magnitude) * 64'd10 + 64'(ch - CHAR_ZERO);
         if (wide > 64'(MAG_MAX)) begin
            wide           = 64'(MAG_MAX);
            pred_saturated = 1'b1;
         end
         pred_magnitude = wide[MAG_W-1:0];
         if (pred_digits != COUNT_MAX) pred_digits++;
      end else if (pred_mode == IN_DIGITS) begin
         // any non-digit, a sign too, or a word past the line length ends the number
         res       = '{1'b1, pred_magnitude, pred_negative, pred_digits, POS_OUT_W'(pos),
                       pred_saturated};
         emitted   = 1'b1;
         pred_mode = SEEK_NUMBER;
      end else if (pred_mode == SIGN_HELD && in_line && is_digit) begin
         pred_mode      = IN_DIGITS;
         pred_magnitude = MAG_W'(ch - CHAR_ZERO);
         pred_saturated = 1'b0;
         pred_digits    = 1;
      end else if (pred_mode == SIGN_HELD && in_line && ch == CHAR_DOT) begin
         res       = '{1'b1, 31'd0, pred_negative, 9'd0, POS_OUT_W'(pos), 1'b0};
         emitted   = 1'b1;
         pred_mode = SEEK_NUMBER;
      end else begin
         // searching, or a held sign dropped: look at the character afresh
         pred_mode = SEEK_NUMBER;
         if (in_line && is_sign) begin
            pred_mode     = SIGN_HELD;
            pred_negative = ch == CHAR_MINUS;
         end else if (in_line && is_digit) begin
            pred_mode      = IN_DIGITS;
            pred_negative  = 1'b0;
            pred_magnitude = MAG_W'(ch - CHAR_ZERO);
            pred_saturated = 1'b0;
            pred_digits    = 1;
         end
      end
      if (pred_position < LINE_LEN) pred_position++;
      if (eol) begin
         // pending digits close at the line end, otherwise a not-found result
         if (!emitted) begin
            if (pred_mode == IN_DIGITS)
               res = '{1'b1, pred_magnitude, pred_negative, pred_digits,
                       POS_OUT_W'(pred_position), pred_saturated};
            else
               res = NOT_FOUND;
            emitted = 1'b1;
         end
         pred_mode     = SEEK_NUMBER;
         pred_position = 0;
      end
      return emitted;
   endfunction

   // offer one word, with random idle cycles ahead of it, and queue what it should yield
   task automatic offer_char(input logic [CHAR_W-1:0] ch, input logic eol, input logic pinned,
                             input sdis_result_type want);
      sdis_result_type res;
      bit              emitted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_character   <= ch;
      req_end_of_line <= eol;
      @(posedge clock);
      // ready is read before the edge updates land, so this is the value the block saw
      while (!req_ready) @(posedge clock);
      emitted = step_scanner(ch, eol, res);
      if (pinned) res = want;
      if (emitted || pinned) numbers_due.push_back(res);
   endtask

   // character mix: mostly digits and signs so numbers form, the rest any byte
   function automatic logic [CHAR_W-1:0] random_char(input int digit_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < digit_pct) return CHAR_W'(CHAR_ZERO + $urandom_range(9));
      if (roll < digit_pct + 10) return CHAR_MINUS;
      if (roll < digit_pct + 18) return CHAR_PLUS;
      if (roll < digit_pct + 26) return CHAR_DOT;
      return CHAR_W'($urandom_range(255));
   endfunction

   // short random lines; some are digit-heavy so long runs reach saturation
   task automatic send_random_lines(input int words);
      int sent;
      int len;
      int digit_pct;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(99) < 15) begin
            digit_pct = 92;
            len       = $urandom_range(8, 16);
         end else begin
            digit_pct = 40;
            len       = $urandom_range(1, 16);
         end
         for (int k = 0; k < len; k++)
            offer_char(random_char(digit_pct), k == len - 1, 1'b0, '0);
         sent += len;
      end
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // receiver: check each accepted result word, then pick ready for the next cycle
   always @(posedge clock) begin
      sdis_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (numbers_due.size() == 0) begin
            $display("%0t: result word with nothing expected, actual found=%0d magnitude=%0d",
                     $time, rsp_found, rsp_magnitude);
            mismatches++;
         end else begin
            want = numbers_due.pop_front();
            check_field("found", want.found, rsp_found);
            check_field("magnitude", want.magnitude, rsp_magnitude);
            check_field("negative", want.negative, rsp_negative);
            check_field("digit_count", want.digit_count, rsp_digit_count);
            check_field("end_position", want.end_position, rsp_end_position);
            check_field("overflow", want.overflow, rsp_overflow);
         end
      end
      if (hold_serial != hold_taken) begin
         hold_taken = hold_serial;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // watchdog: too long with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles with odds of 37 percent, receiver 59
      send_idle_pct = 37;
      recv_idle_pct = 59;
      for (int i = 0; i < $size(DIRECTED_ROWS); i++)
         offer_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].eol, DIRECTED_ROWS[i].pinned,
                    DIRECTED_ROWS[i].want);
      send_random_lines(PHASE_WORDS);

      // sender pauses until every owed result has come back
      req_valid <= 1'b0;
      while (numbers_due.size() != 0) @(posedge clock);

      // phase two: the odds swapped
      send_idle_pct = 59;
      recv_idle_pct = 37;
      send_random_lines(PHASE_WORDS);

      // phase three: no idling; a long receiver stall while words keep coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_serial++;
      // one line past the line length: digits straddle the limit, the tail is ignored
      for (int k = 0; k < LINE_LEN + 4; k++) begin
         if (k >= LINE_LEN - 6 && k <= LINE_LEN + 1)
            offer_char(CHAR_W'(CHAR_ZERO + $urandom_range(9)), 1'b0, 1'b0, '0);
         else if (k == LINE_LEN + 2)
            offer_char(CHAR_MINUS, 1'b0, 1'b0, '0);
         else
            offer_char(random_char(40), k == LINE_LEN + 3, 1'b0, '0);
      end
      send_random_lines(PHASE_WORDS);

      req_valid <= 1'b0;
      while (numbers_due.size() != 0) @(posedge clock);
      // wait a margin in which a stray extra result would show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire
